### sv/octave_value_noise_2d_unit_defines.svh
// assertion macros shared by the block
`ifndef OCTAVE_VALUE_NOISE_2D_UNIT_DEFINES_SVH
`define OCTAVE_VALUE_NOISE_2D_UNIT_DEFINES_SVH

// condition must hold in the same cycle
`define OVN_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("ovn check failed");

// condition must hold in the following cycle
`define OVN_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("ovn check failed");

`endif

### sv/ovn_pkg.sv
package ovn_pkg;

    // defaults for the top level parameters
    localparam int unsigned DEF_MAX_OCTAVES    = 8;
    localparam int unsigned DEF_COS_TABLE_BITS = 10;

    // field and datapath widths
    localparam int unsigned COORD_W     = 32;
    localparam int unsigned NOISE_W     = 16;
    localparam int unsigned PERSIST_W   = 16;
    localparam int unsigned COUNT_W     = 4;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned SCALE_W     = 48;
    localparam int unsigned FRAC_W      = 16;
    localparam int unsigned SMOOTH_W    = 36;
    localparam int unsigned DIFF_W      = 37;
    localparam int unsigned LO_W        = 20;
    localparam int unsigned PART_W      = 37;
    localparam int unsigned PROD_W      = 56;
    localparam int unsigned FADE_W      = 17;
    localparam int unsigned QUOT_W      = 16;
    localparam int unsigned OPER_W      = 33;
    localparam int unsigned MUL_W       = 66;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PERSISTENCE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OCTAVE_COUNT = 1'b1;

    // register reset values
    localparam logic [PERSIST_W-1:0] PERSIST_RESET = 16'd16384;
    localparam logic [COUNT_W-1:0]   COUNT_RESET   = 4'd4;

    // 1.0 in Q1.15
    localparam logic [15:0] ONE_Q15 = 16'd32768;

    // lattice hash constants
    localparam logic [31:0] HASH_C1   = 32'd15731;
    localparam logic [31:0] HASH_C2   = 32'd789221;
    localparam logic [31:0] HASH_C3   = 32'd1376312589;
    localparam logic [31:0] HASH_MASK = 32'h7fffffff;
    localparam logic [31:0] HASH_BIAS = 32'h40000000;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_OCT_INIT,
        ST_H_N,
        ST_H_M1,
        ST_H_M2,
        ST_H_M3,
        ST_H_ACC,
        ST_BL_DIFF,
        ST_BL_LO,
        ST_BL_HI,
        ST_BL_SUM,
        ST_WT_LOAD,
        ST_WT_LO,
        ST_WT_HI,
        ST_WT_SUM,
        ST_W_MUL,
        ST_W_UPD,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        BL_X0,
        BL_X1,
        BL_Y
    } blend_sel_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // absolute value of a coordinate, most negative saturates
    function automatic logic [30:0] abs_coord(input logic [31:0] v);
        logic [31:0] neg;
        neg = ~v + 32'd1;
        if (v == 32'h80000000)
            return 31'h7fffffff;
        else if (v[31])
            return neg[30:0];
        else
            return v[30:0];
    endfunction

    // one entry of the (1-cos(pi t))/2 table, Taylor series of sin in Q2.30
    function automatic logic [FADE_W-1:0] fade_entry(input int unsigned k,
                                                     input int unsigned bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        f;
        logic signed [63:0] s;
        int unsigned        j;
        x    = (64'd1686629713 * 64'(k)) >> bits;
        x2   = (x * x) >> 30;
        term = x;
        s    = signed'(x);
        for (j = 1; j <= 10; j++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * j) * (2 * j + 1));
            if ((j & 1) != 0)
                s = s - signed'(term);
            else
                s = s + signed'(term);
        end
        if (s < 0)
            s = 0;
        f = (unsigned'(s) * unsigned'(s)) >> 30;
        return FADE_W'((f + 64'd8192) >> 14);
    endfunction

endpackage

### sv/ovn_mul.sv
module ovn_mul (
    input  logic                                   clk,
    input  logic signed [ovn_pkg::OPER_W-1:0]      a,
    input  logic signed [ovn_pkg::OPER_W-1:0]      b,
    output logic signed [ovn_pkg::MUL_W-1:0]       prod_reg
);
    import ovn_pkg::*;

    // shared signed multiplier with registered product
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

endmodule

### sv/ovn_div.sv
module ovn_div #(
    parameter int unsigned W = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [W-1:0]                  num,
    input  logic [W-1:0]                  den,
    output ovn_pkg::div_status_t          status,
    output logic [ovn_pkg::QUOT_W-1:0]    quotient
);
    import ovn_pkg::*;

    localparam int unsigned STEP_W = $clog2(QUOT_W);

    logic [W-1:0]      rem_reg;
    logic [W-1:0]      den_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              ge;

    assign ge = rem_reg >= den_reg;

    // step counter and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(QUOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den << (QUOT_W - 1);
        end
        else if (busy_reg)
        begin
            if (ge)
                rem_reg <= rem_reg - den_reg;
            quot_reg <= {quot_reg[QUOT_W-2:0], ge};
            den_reg  <= den_reg >> 1;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quot_reg;

endmodule

### sv/ovn_fade_rom.sv
module ovn_fade_rom #(
    parameter int unsigned ADDR_W = 10
) (
    input  logic                            clk,
    input  logic [ADDR_W-1:0]               addr,
    output logic [ovn_pkg::FADE_W-1:0]      fade_reg
);
    import ovn_pkg::*;

    localparam int unsigned DEPTH = 1 << ADDR_W;

    logic [FADE_W-1:0] rom [DEPTH];

    // table contents fixed at elaboration
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_entry
        localparam logic [FADE_W-1:0] ENTRY = fade_entry(k, ADDR_W);
        assign rom[k] = ENTRY;
    end

    // registered read
    always_ff @(posedge clk)
    begin
        fade_reg <= rom[addr];
    end

endmodule

### sv/octave_value_noise_2d_unit.sv
// Fractal value noise over a 2D plane.
// Input channel: sample_valid/sample_ready with x_coord and y_coord (signed
// Q16.16). Output channel: noise_valid/noise_ready with noise_value (Q1.15,
// 0..32768). Each transaction on the input yields exactly one on the output.
// Configuration: cfg_we with cfg_index and cfg_data writes persistence
// (index 0) or octave_count (index 1); write only while the block is idle.
// One sample is worked on at a time; sample_ready is low from acceptance
// until the result is loaded into the output register.
// Each octave runs one setup state, 16 lattice hashes through the shared
// multiplier, three blends and the weighting. The final normalization is a
// 16-step restoring division with its own start and finish states.
// The output register lets the next sample be accepted while a result waits;
// a stalled receiver holds a finished sample in the last state until the
// output register frees up. Reset clears the sequencer and output valid and
// restores persistence to 0.5 and the octave count to 4.
`include "octave_value_noise_2d_unit_defines.svh"

module octave_value_noise_2d_unit #(
    parameter int unsigned MAX_OCTAVES    = ovn_pkg::DEF_MAX_OCTAVES,
    parameter int unsigned COS_TABLE_BITS = ovn_pkg::DEF_COS_TABLE_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [ovn_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [ovn_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   sample_valid,
    output logic                                   sample_ready,
    input  logic signed [ovn_pkg::COORD_W-1:0]     x_coord,
    input  logic signed [ovn_pkg::COORD_W-1:0]     y_coord,
    output logic                                   noise_valid,
    input  logic                                   noise_ready,
    output logic [ovn_pkg::NOISE_W-1:0]            noise_value
);
    import ovn_pkg::*;

    localparam int unsigned OCT_W = $clog2(MAX_OCTAVES + 1);
    localparam int unsigned WS_W  = 16 + OCT_W;
    localparam int unsigned TOT_W = 57 + $clog2(MAX_OCTAVES);
    localparam int unsigned DIV_W = TOT_W + 1;

    state_t                      state_reg;
    state_t                      state_next;
    logic [PERSIST_W-1:0]        persistence_reg;
    logic [COUNT_W-1:0]          octave_count_reg;
    logic [SCALE_W-1:0]          sx_reg;
    logic [SCALE_W-1:0]          sy_reg;
    logic [PERSIST_W-1:0]        p_reg;
    logic [OCT_W-1:0]            oct_reg;
    logic [OCT_W-1:0]            cnt_reg;
    logic [15:0]                 w_reg;
    logic [WS_W-1:0]             wsum_reg;
    logic signed [TOT_W-1:0]     total_reg;
    logic [3:0]                  g_reg;
    blend_sel_t                  bsel_reg;
    logic [31:0]                 n_reg;
    logic signed [SMOOTH_W-1:0]  c00_reg;
    logic signed [SMOOTH_W-1:0]  c10_reg;
    logic signed [SMOOTH_W-1:0]  c01_reg;
    logic signed [SMOOTH_W-1:0]  c11_reg;
    logic signed [DIFF_W-1:0]    diff_reg;
    logic [PART_W-1:0]           pl_reg;
    logic [NOISE_W-1:0]          noise_reg;
    logic                        noise_valid_reg;

    logic [PERSIST_W-1:0]        p_clamp;
    logic [4:0]                  cnt_sel;
    logic [OCT_W-1:0]            cnt_clamp;
    logic [31:0]                 lat_x;
    logic [31:0]                 lat_y;
    logic [31:0]                 n57;
    logic [31:0]                 n_hash;
    logic [31:0]                 m_hash;
    logic signed [31:0]          lat_val;
    logic signed [OPER_W-1:0]    mul_a;
    logic signed [OPER_W-1:0]    mul_b;
    logic signed [MUL_W-1:0]     prod_reg;
    logic [FADE_W-1:0]           fade_reg;
    logic [COS_TABLE_BITS-1:0]   fade_addr;
    logic [FADE_W-1:0]           factor;
    logic signed [SMOOTH_W-1:0]  blend_a;
    logic signed [SMOOTH_W-1:0]  blend_b;
    logic signed [PROD_W-1:0]    p_full;
    logic signed [PROD_W-1:0]    p_rnd;
    logic signed [SMOOTH_W-1:0]  blend_res;
    logic [TOT_W-1:0]            mag;
    logic [DIV_W-1:0]            div_num;
    logic [DIV_W-1:0]            div_den;
    logic                        div_start;
    div_status_t                 div_stat;
    logic [QUOT_W-1:0]           quot;
    logic [NOISE_W-1:0]          q_out;
    logic                        out_load;

    // weighted contribution of one lattice point to one smoothed corner
    function automatic logic signed [SMOOTH_W-1:0] corner_term(
        input logic [1:0]         gx,
        input logic [1:0]         gy,
        input logic               cx,
        input logic               cy,
        input logic signed [31:0] v
    );
        logic [2:0]                 ex;
        logic [2:0]                 ey;
        logic signed [SMOOTH_W-1:0] vx;
        ex = {1'b0, gx} - {2'b00, cx};
        ey = {1'b0, gy} - {2'b00, cy};
        vx = SMOOTH_W'(v);
        if (ex > 3'd2 || ey > 3'd2)
            return '0;
        else if (ex == 3'd1 && ey == 3'd1)
            return vx <<< 2;
        else if (ex == 3'd1 || ey == 3'd1)
            return vx <<< 1;
        else
            return vx;
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            persistence_reg  <= PERSIST_RESET;
            octave_count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PERSISTENCE:  persistence_reg  <= cfg_data;
                CFG_OCTAVE_COUNT: octave_count_reg <= cfg_data[COUNT_W-1:0];
            endcase
        end
    end

    // clamped settings captured per sample
    assign p_clamp = (persistence_reg > ONE_Q15) ? ONE_Q15 : persistence_reg;

    always_comb
    begin
        if (octave_count_reg == '0)
            cnt_sel = 5'd1;
        else if ({1'b0, octave_count_reg} > 5'(MAX_OCTAVES))
            cnt_sel = 5'(MAX_OCTAVES);
        else
            cnt_sel = {1'b0, octave_count_reg};
    end

    assign cnt_clamp = OCT_W'(cnt_sel);

    // lattice point and first hash step
    assign lat_x  = sx_reg[FRAC_W +: 32] + {30'd0, g_reg[1:0]} - 32'd1;
    assign lat_y  = sy_reg[FRAC_W +: 32] + {30'd0, g_reg[3:2]} - 32'd1;
    assign n57    = lat_x + (lat_y << 6) - (lat_y << 3) + lat_y;
    assign n_hash = n57 ^ (n57 << 13);

    // lattice value from the last hash product
    assign m_hash  = (prod_reg[31:0] + HASH_C3) & HASH_MASK;
    assign lat_val = signed'(HASH_BIAS - m_hash);

    // fade table, x fraction for the first two blends, y for the last
    assign fade_addr = (bsel_reg == BL_Y) ? sy_reg[FRAC_W-1 -: COS_TABLE_BITS]
                                          : sx_reg[FRAC_W-1 -: COS_TABLE_BITS];

    ovn_fade_rom #(
        .ADDR_W (COS_TABLE_BITS)
    ) u_fade (
        .clk      (clk),
        .addr     (fade_addr),
        .fade_reg (fade_reg)
    );

    // blend operand selection
    always_comb
    begin
        unique case (bsel_reg)
            BL_X0:
            begin
                blend_a = c00_reg;
                blend_b = c10_reg;
            end
            BL_X1:
            begin
                blend_a = c01_reg;
                blend_b = c11_reg;
            end
            BL_Y:
            begin
                blend_a = c00_reg;
                blend_b = c01_reg;
            end
            default:
            begin
                blend_a = c00_reg;
                blend_b = c10_reg;
            end
        endcase
    end

    assign factor = (state_reg == ST_WT_LO || state_reg == ST_WT_HI)
                    ? {1'b0, w_reg} : fade_reg;

    // recombine the two partial products
    assign p_full    = signed'({prod_reg[PROD_W-LO_W-1:0], {LO_W{1'b0}}})
                     + signed'({{(PROD_W-PART_W){1'b0}}, pl_reg});
    assign p_rnd     = p_full + PROD_W'(32768);
    assign blend_res = blend_a + p_rnd[16 +: SMOOTH_W];

    ovn_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod_reg)
    );

    // normalization divider
    assign mag     = total_reg[TOT_W-1] ? unsigned'(-total_reg) : unsigned'(total_reg);
    assign div_num = DIV_W'(mag) + (DIV_W'(wsum_reg) << 18);
    assign div_den = DIV_W'(wsum_reg) << 19;

    ovn_div #(
        .W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .status   (div_stat),
        .quotient (quot)
    );

    assign q_out    = (quot > ONE_Q15) ? ONE_Q15 : quot;
    assign out_load = !noise_valid_reg || noise_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (sample_valid) state_next = ST_OCT_INIT;
            ST_OCT_INIT:  state_next = ST_H_N;
            ST_H_N:       state_next = ST_H_M1;
            ST_H_M1:      state_next = ST_H_M2;
            ST_H_M2:      state_next = ST_H_M3;
            ST_H_M3:      state_next = ST_H_ACC;
            ST_H_ACC:     state_next = (g_reg == 4'hf) ? ST_BL_DIFF : ST_H_N;
            ST_BL_DIFF:   state_next = ST_BL_LO;
            ST_BL_LO:     state_next = ST_BL_HI;
            ST_BL_HI:     state_next = ST_BL_SUM;
            ST_BL_SUM:    state_next = (bsel_reg == BL_Y) ? ST_WT_LOAD : ST_BL_DIFF;
            ST_WT_LOAD:   state_next = ST_WT_LO;
            ST_WT_LO:     state_next = ST_WT_HI;
            ST_WT_HI:     state_next = ST_WT_SUM;
            ST_WT_SUM:    state_next = ST_W_MUL;
            ST_W_MUL:     state_next = ST_W_UPD;
            ST_W_UPD:     state_next = (oct_reg + 1'b1 == cnt_reg) ? ST_DIV_START
                                                                   : ST_OCT_INIT;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:  if (div_stat.done) state_next = ST_FINISH;
            ST_FINISH:    if (out_load) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs and multiplier operands
    always_comb
    begin
        sample_ready = 1'b0;
        div_start    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        unique case (state_reg)
            ST_IDLE:      sample_ready = 1'b1;
            ST_H_M1:
            begin
                mul_a = {1'b0, n_reg};
                mul_b = {1'b0, n_reg};
            end
            ST_H_M2:
            begin
                mul_a = {1'b0, prod_reg[31:0]};
                mul_b = {1'b0, HASH_C1};
            end
            ST_H_M3:
            begin
                mul_a = {1'b0, n_reg};
                mul_b = {1'b0, prod_reg[31:0] + HASH_C2};
            end
            ST_BL_LO, ST_WT_LO:
            begin
                mul_a = {{(OPER_W-LO_W){1'b0}}, diff_reg[LO_W-1:0]};
                mul_b = {{(OPER_W-FADE_W){1'b0}}, factor};
            end
            ST_BL_HI, ST_WT_HI:
            begin
                mul_a = {{(OPER_W-DIFF_W+LO_W){diff_reg[DIFF_W-1]}},
                         diff_reg[DIFF_W-1:LO_W]};
                mul_b = {{(OPER_W-FADE_W){1'b0}}, factor};
            end
            ST_W_MUL:
            begin
                mul_a = {{(OPER_W-16){1'b0}}, w_reg};
                mul_b = {{(OPER_W-PERSIST_W){1'b0}}, p_reg};
            end
            ST_DIV_START: div_start = 1'b1;
            default:      ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            oct_reg         <= '0;
            g_reg           <= '0;
            bsel_reg        <= BL_X0;
            noise_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE)
                oct_reg <= '0;
            else if (state_reg == ST_W_UPD)
                oct_reg <= oct_reg + 1'b1;
            if (state_reg == ST_OCT_INIT)
            begin
                g_reg    <= '0;
                bsel_reg <= BL_X0;
            end
            else if (state_reg == ST_H_ACC)
                g_reg <= g_reg + 1'b1;
            else if (state_reg == ST_BL_SUM)
                bsel_reg <= (bsel_reg == BL_X0) ? BL_X1 : BL_Y;
            if (state_reg == ST_FINISH && out_load)
                noise_valid_reg <= 1'b1;
            else if (noise_ready)
                noise_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                sx_reg    <= SCALE_W'(abs_coord(x_coord));
                sy_reg    <= SCALE_W'(abs_coord(y_coord));
                p_reg     <= p_clamp;
                cnt_reg   <= cnt_clamp;
                w_reg     <= ONE_Q15;
                wsum_reg  <= '0;
                total_reg <= '0;
            end
            ST_OCT_INIT:
            begin
                c00_reg <= '0;
                c10_reg <= '0;
                c01_reg <= '0;
                c11_reg <= '0;
            end
            ST_H_N:       n_reg <= n_hash;
            ST_H_ACC:
            begin
                c00_reg <= c00_reg + corner_term(g_reg[1:0], g_reg[3:2], 1'b0, 1'b0, lat_val);
                c10_reg <= c10_reg + corner_term(g_reg[1:0], g_reg[3:2], 1'b1, 1'b0, lat_val);
                c01_reg <= c01_reg + corner_term(g_reg[1:0], g_reg[3:2], 1'b0, 1'b1, lat_val);
                c11_reg <= c11_reg + corner_term(g_reg[1:0], g_reg[3:2], 1'b1, 1'b1, lat_val);
            end
            ST_BL_DIFF:   diff_reg <= DIFF_W'(blend_b) - DIFF_W'(blend_a);
            ST_BL_HI, ST_WT_HI:
                          pl_reg <= prod_reg[PART_W-1:0];
            ST_BL_SUM:
            begin
                if (bsel_reg == BL_X1)
                    c01_reg <= blend_res;
                else
                    c00_reg <= blend_res;
            end
            ST_WT_LOAD:   diff_reg <= DIFF_W'(c00_reg);
            ST_WT_SUM:
            begin
                total_reg <= total_reg + TOT_W'(p_full);
                wsum_reg  <= wsum_reg + WS_W'(w_reg);
            end
            ST_W_UPD:
            begin
                w_reg  <= 16'((prod_reg[31:0] + 32'd16384) >> 15);
                sx_reg <= sx_reg << 1;
                sy_reg <= sy_reg << 1;
            end
            ST_FINISH:    if (out_load) noise_reg <= q_out;
            default:      ;
        endcase
    end

    assign noise_valid = noise_valid_reg;
    assign noise_value = noise_reg;

    // checks
    `OVN_ASSERT_NEXT(a_busy_after_accept, sample_valid && sample_ready, !sample_ready)
    `OVN_ASSERT_NOW(a_noise_in_range, noise_valid, noise_value <= ONE_Q15)
    `OVN_ASSERT_NOW(a_div_idle_when_ready, sample_ready, !div_stat.busy)

endmodule

### dv/tb_octave_value_noise_2d_unit.sv
`timescale 1ns / 100ps

// expected noise values, computed from a private model of the octave sum
class noise_scoreboard;
    int unsigned        fade_lut [1024];
    bit [15:0]          persist;
    bit [3:0]           octaves;
    bit [15:0]          noise_queue [$];
    int unsigned        mismatches;
    int unsigned        checked;

    function new();
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned term;
        longint unsigned sq;
        longint          sn;
        // (1-cos(pi t))/2 as sin^2, sine by Taylor series in Q2.30
        for (int k = 0; k < 1024; k++)
        begin
            ang  = (64'd1686629713 * longint'(k)) >> 10;
            ang2 = (ang * ang) >> 30;
            term = ang;
            sn   = longint'(ang);
            for (int j = 1; j <= 10; j++)
            begin
                term = ((term * ang2) >> 30) / longint'((2 * j) * (2 * j + 1));
                if (j % 2 == 1)
                    sn = sn - longint'(term);
                else
                    sn = sn + longint'(term);
            end
            if (sn < 0)
                sn = 0;
            sq = (longint'(sn) * longint'(sn)) >> 30;
            fade_lut[k] = int'((sq + 64'd8192) >> 14);
        end
        persist    = 16'd16384;
        octaves    = 4'd4;
        mismatches = 0;
        checked    = 0;
    endfunction

    function void set_reg(bit index, bit [15:0] data);
        if (index == ovn_pkg::CFG_PERSISTENCE)
            persist = data;
        else
            octaves = data[3:0];
    endfunction

    // integer lattice hash, Q2.30 value in -1..1
    function longint lattice_hash(bit [31:0] lx, bit [31:0] ly);
        bit [31:0] n;
        bit [31:0] m;
        n = lx + ly * 32'd57;
        n = (n << 13) ^ n;
        m = n * n * 32'd15731 + 32'd789221;
        m = n * m + 32'd1376312589;
        m = m & 32'h7fffffff;
        return 64'sd1073741824 - longint'({32'b0, m});
    endfunction

    // 3x3 weighted patch sum, scaled by 16
    function longint smooth_at(bit [31:0] lx, bit [31:0] ly);
        bit [31:0] xm;
        bit [31:0] xp;
        bit [31:0] ym;
        bit [31:0] yp;
        xm = lx - 1; xp = lx + 1; ym = ly - 1; yp = ly + 1;
        return lattice_hash(xm, ym) + lattice_hash(xp, ym) + lattice_hash(xm, yp)
            + lattice_hash(xp, yp)
            + 2 * (lattice_hash(xm, ly) + lattice_hash(xp, ly)
                   + lattice_hash(lx, ym) + lattice_hash(lx, yp))
            + 4 * lattice_hash(lx, ly);
    endfunction

    // a + (b-a)*f/65536, ties rounded up
    function longint fade_mix(longint a, longint b, bit [15:0] frac);
        longint f;
        f = longint'(fade_lut[frac >> 6]);
        return a + (((b - a) * f + 32768) >>> 16);
    endfunction

    function bit [31:0] magnitude(bit [31:0] v);
        if (v == 32'h80000000)
            return 32'h7fffffff;
        else if (v[31])
            return -v;
        return v;
    endfunction

    function bit [15:0] octave_noise(bit [31:0] xc, bit [31:0] yc);
        bit [63:0]       sx;
        bit [63:0]       sy;
        bit [31:0]       ix;
        bit [31:0]       iy;
        longint          r;
        longint          total;
        longint unsigned wt;
        longint unsigned wsum;
        longint unsigned mag;
        longint unsigned den;
        longint unsigned q;
        longint unsigned p;
        int              cnt;
        p     = (persist > 16'd32768) ? 32768 : persist;
        cnt   = (octaves < 1) ? 1 : ((octaves > 8) ? 8 : octaves);
        wt    = 32768;
        wsum  = 0;
        total = 0;
        for (int i = 0; i < cnt; i++)
        begin
            sx = {32'b0, magnitude(xc)} << i;
            sy = {32'b0, magnitude(yc)} << i;
            ix = sx[47:16];
            iy = sy[47:16];
            r  = fade_mix(fade_mix(smooth_at(ix, iy), smooth_at(ix + 1, iy), sx[15:0]),
                          fade_mix(smooth_at(ix, iy + 1), smooth_at(ix + 1, iy + 1),
                                   sx[15:0]),
                          sy[15:0]);
            total += r * longint'(wt);
            wsum  += wt;
            wt     = (wt * p + 16384) >> 15;
        end
        mag = (total < 0) ? -total : total;
        den = wsum << 19;
        q   = (mag + (den >> 1)) / den;
        if (q > 32768)
            q = 32768;
        return q[15:0];
    endfunction

    function void note_sample(bit [31:0] xc, bit [31:0] yc);
        noise_queue.push_back(octave_noise(xc, yc));
    endfunction

    function void check_noise(bit [15:0] got);
        bit [15:0] want;
        checked++;
        if (noise_queue.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected noise transaction, expected none, actual %0d",
                     $time, got);
            return;
        end
        want = noise_queue.pop_front();
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: noise_value mismatch, expected %0d, actual %0d",
                     $time, want, got);
        end
    endfunction
endclass

module tb_octave_value_noise_2d_unit;
    import ovn_pkg::*;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    sample_valid;
    logic                    sample_ready;
    logic signed [31:0]      x_coord;
    logic signed [31:0]      y_coord;
    logic                    noise_valid;
    logic                    noise_ready;
    logic [NOISE_W-1:0]      noise_value;

    noise_scoreboard         sb;
    bit                      calm;
    int unsigned             sent;
    int unsigned             idle_cycles;

    octave_value_noise_2d_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .noise_valid  (noise_valid),
        .noise_ready  (noise_ready),
        .noise_value  (noise_value)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // output transactions
    always @(posedge clk)
    begin
        if (rst_n && noise_valid && noise_ready)
            sb.check_noise(noise_value);
    end

    // receiver stalls in random bursts
    initial
    begin
        int n;
        noise_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                noise_ready = 1'b0;
                n = $urandom_range(1, 12);
                repeat (n) @(negedge clk);
            end
            noise_ready = 1'b1;
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((sample_valid && sample_ready) || (noise_valid && noise_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 6000)
        begin
            $display("%0t: watchdog expired", $time);
            $display("tb_octave_value_noise_2d_unit NOT OK");
            $finish;
        end
    end

    // one sample transaction, entered and left at a falling edge
    task automatic send_sample(bit [31:0] xc, bit [31:0] yc);
        int n;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            sample_valid = 1'b0;
            n = $urandom_range(1, 12);
            repeat (n) @(negedge clk);
        end
        sample_valid = 1'b1;
        x_coord      = xc;
        y_coord      = yc;
        do
            @(posedge clk);
        while (!sample_ready);
        sb.note_sample(xc, yc);
        sent++;
        @(negedge clk);
    endtask

    // wait for every pending result, then let the block settle
    task automatic drain();
        sample_valid = 1'b0;
        while (sb.noise_queue.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(bit index, bit [15:0] data);
        drain();
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        sb.set_reg(index, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_config(bit [15:0] p, bit [3:0] c);
        write_reg(CFG_PERSISTENCE, p);
        write_reg(CFG_OCTAVE_COUNT, {12'($urandom_range(0, 4095)), c});
    endtask

    function automatic bit [31:0] rand_coord();
        bit [31:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2, 3: v = $urandom_range(0, 32'h000fffff);
            4:    v = -$urandom_range(0, 32'h000fffff);
            default:
            begin
                case ($urandom_range(0, 5))
                    0: v = 32'h80000000;
                    1: v = 32'h7fffffff;
                    2: v = 32'hffffffff;
                    3: v = 32'h0000ffff;
                    4: v = 32'h00010000;
                    default: v = 32'h0;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic random_run(int count);
        for (int i = 0; i < count; i++)
            send_sample(rand_coord(), rand_coord());
    endtask

    initial
    begin
        bit [31:0] corner [8];
        sb           = new();
        calm         = 1'b0;
        sent         = 0;
        idle_cycles  = 0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        sample_valid = 1'b0;
        x_coord      = '0;
        y_coord      = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed corners under reset settings, then wrapping with eight octaves
        corner = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                   32'h0000ffff, 32'h00010000, 32'hffff0000, 32'h80000001};
        for (int i = 0; i < 8; i++)
            send_sample(corner[i], corner[7 - i]);
        send_sample(32'h00008000, 32'hffff8000);
        set_config(16'd32768, 4'd8);
        for (int i = 0; i < 8; i++)
            send_sample(corner[i], corner[(i + 3) % 8]);
        set_config(16'd65535, 4'd0);
        send_sample(32'h7fffffff, 32'h80000000);
        send_sample(32'h00012345, 32'hfffe0000);
        set_config(16'd0, 4'd15);
        send_sample(32'h7fffffff, 32'h7fffffff);
        send_sample(32'h00030001, 32'h00000001);

        // random phases across settings, mostly short octave counts
        set_config(16'd0, 4'd1);
        random_run(300);
        set_config(16'd65535, 4'd0);
        random_run(240);
        set_config(16'd12000, 4'd2);
        random_run(120);
        // hold off until the block has emptied
        drain();
        random_run(120);
        set_config(16'd16384, 4'd3);
        random_run(240);
        set_config(16'd32768, 4'd8);
        random_run(70);
        set_config(16'd40000, 4'd15);
        random_run(50);
        set_config(16'd7, 4'd5);
        random_run(180);
        set_config(16'($urandom_range(0, 65535)), 4'd4);
        random_run(200);
        set_config(16'd20000, 4'd1);
        calm = 1'b1;
        random_run(320);

        drain();
        repeat (900) @(negedge clk);
        $display("covered %0d samples over persistence 0..65535 and octave counts 0..15,",
                 sent);
        $display("with corner coordinates, lattice wrap and random stalls on both sides");
        if (sb.mismatches == 0 && sb.noise_queue.size() == 0)
            $display("tb_octave_value_noise_2d_unit OK");
        else
            $display("tb_octave_value_noise_2d_unit NOT OK");
        $finish;
    end
endmodule
